// ===== sv/fbpa_pkg.sv =====
`timescale 1ns / 1ps
package fbpa_pkg;

  localparam int IdxW    = 8;
  localparam int CountW  = 9;
  localparam int StatusW = 2;
  localparam int FuncW   = 1;

  // operation codes
  localparam logic [FuncW-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FuncW-1:0] FUNC_FREE  = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

  // the link table always spans every 8-bit block index
  localparam int LinkDepth = 256;

endpackage

// ===== sv/fbpa_in_if.sv =====
`timescale 1ns / 1ps
interface fbpa_in_if;
  import fbpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [IdxW-1:0]   free_index;

  modport source (output valid, output func, output free_index, input ready);
  modport sink   (input valid, input func, input free_index, output ready);
endinterface

// ===== sv/fbpa_out_if.sv =====
`timescale 1ns / 1ps
interface fbpa_out_if;
  import fbpa_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IdxW-1:0]    block_index;

  modport source (output valid, output status, output block_index, input ready);
  modport sink   (input valid, input status, input block_index, output ready);
endinterface

// ===== sv/fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps
// fixed block pool allocator
// in_item carries requests: func selects allocate or free, free_index names the
// block handed back by a free. out_item returns one item per request: status
// (done, pool empty, pool already full) and block_index of the allocated block.
// cfg_we / cfg_wdata write block_count, which reinitializes the pool; write it
// only while no request is in flight.
// latency: the result item is shown in the cycle after the request is taken.
// a free leaves the allocator in S_IDLE, ready for the next request; an allocate
// that leaves blocks on the list passes through S_LINK before the next request
// is taken, since the new head comes from the registered read of the link table at the old head.
// free list links live in one 256-entry synchronous ram that is never cleared;
// the list is built lazily, one untouched block per allocate.
// reset: block_count 256 (clamped to MAX_BLOCKS), every block free.
// a new request is taken only when the output register is empty or being
// drained this cycle, so a stalled receiver holds off the input side.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  fbpa_in_if.sink                     in_item,
  fbpa_out_if.source                  out_item,
  input  logic                        cfg_we,
  input  logic [fbpa_pkg::CountW-1:0] cfg_wdata
);
  import fbpa_pkg::*;

  localparam logic [CountW-1:0] Limit =
    (MAX_BLOCKS > LinkDepth) ? CountW'(LinkDepth) : CountW'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LINK = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CountW-1:0]  count_r, count_nxt;
  logic [CountW-1:0]  free_cnt_r, free_cnt_nxt;
  logic [CountW-1:0]  touched_r, touched_nxt;
  logic [IdxW-1:0]    head_r, head_nxt;
  logic               head_vld_r, head_vld_nxt;
  logic               fwd_r, fwd_nxt;
  logic [IdxW-1:0]    fwd_val_r, fwd_val_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [StatusW-1:0] out_status_r, out_status_nxt;
  logic [IdxW-1:0]    out_blk_r, out_blk_nxt;

  logic              acc;
  logic              is_alloc;
  logic              lazy;
  logic              pool_full;
  logic [CountW-1:0] cfg_count;
  logic [IdxW-1:0]   touched_lo;
  logic [IdxW-1:0]   touched_inc;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [IdxW-1:0]   ram_wdata;
  logic [IdxW-1:0]   ram_rdata;

  assign in_item.ready = (state_r == S_IDLE) && (!out_vld_r || out_item.ready);
  assign acc           = in_item.valid && in_item.ready;
  assign is_alloc      = (in_item.func == FUNC_ALLOC);
  assign lazy          = is_alloc && (touched_r < count_r);
  assign pool_full     = (free_cnt_r >= count_r);
  assign touched_lo    = touched_r[IdxW-1:0];
  assign touched_inc   = touched_lo + IdxW'(1);

  always_comb begin
    cfg_count = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_count = CountW'(1);
    end else if (cfg_wdata > Limit) begin
      cfg_count = Limit;
    end
  end

  // lazy link write on allocate, push write on a free that does not find the pool full
  always_comb begin
    ram_we    = acc && (is_alloc ? lazy : !pool_full);
    ram_waddr = is_alloc ? touched_lo : in_item.free_index;
    ram_wdata = is_alloc ? touched_inc : (head_vld_r ? head_r : touched_lo);
  end

  fbpa_ram #(
    .WIDTH (IdxW),
    .DEPTH (LinkDepth)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    free_cnt_nxt   = free_cnt_r;
    touched_nxt    = touched_r;
    head_nxt       = head_r;
    head_vld_nxt   = head_vld_r;
    fwd_nxt        = fwd_r;
    fwd_val_nxt    = fwd_val_r;
    out_vld_nxt    = out_vld_r;
    out_status_nxt = out_status_r;
    out_blk_nxt    = out_blk_r;

    if (out_item.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = ST_DONE;
          out_blk_nxt    = '0;
          if (is_alloc) begin
            if (lazy) begin
              touched_nxt = touched_r + CountW'(1);
            end
            if (free_cnt_r != '0) begin
              out_blk_nxt  = head_r;
              free_cnt_nxt = free_cnt_r - CountW'(1);
              if (free_cnt_r == CountW'(1)) begin
                head_vld_nxt = 1'b0;
              end else begin
                // the head's link may be the one written this same cycle
                state_nxt   = S_LINK;
                fwd_nxt     = lazy && (touched_lo == head_r);
                fwd_val_nxt = touched_inc;
              end
            end else begin
              out_status_nxt = ST_EMPTY;
            end
          end else begin
            if (pool_full) begin
              out_status_nxt = ST_FULL;
            end else begin
              head_nxt     = in_item.free_index;
              head_vld_nxt = 1'b1;
              free_cnt_nxt = free_cnt_r + CountW'(1);
            end
          end
        end
      end
      S_LINK: begin
        head_nxt  = fwd_r ? fwd_val_r : ram_rdata;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      count_nxt    = cfg_count;
      free_cnt_nxt = cfg_count;
      touched_nxt  = '0;
      head_nxt     = '0;
      head_vld_nxt = 1'b1;
      state_nxt    = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= Limit;
      free_cnt_r <= Limit;
      touched_r  <= '0;
      head_r     <= '0;
      head_vld_r <= 1'b1;
      fwd_r      <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      free_cnt_r <= free_cnt_nxt;
      touched_r  <= touched_nxt;
      head_r     <= head_nxt;
      head_vld_r <= head_vld_nxt;
      fwd_r      <= fwd_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_val_r    <= fwd_val_nxt;
    out_status_r <= out_status_nxt;
    out_blk_r    <= out_blk_nxt;
  end

  assign out_item.valid       = out_vld_r;
  assign out_item.status      = out_status_r;
  assign out_item.block_index = out_blk_r;

endmodule

// ===== sv/fbpa_ram.sv =====
`timescale 1ns / 1ps
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read during write to the same address returns the old contents
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule
